// File: rtl/nsp_pkg.sv
// Package for the number string parser: character codes, parse phases
// and the hex digit decoder. No dependencies.
package nsp_pkg;

  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned ACC_BITS_DEF = 32;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LA     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UA     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF     = 8'h46;

  typedef enum logic [1:0] {
    PH_SKIP = 2'd0,
    PH_HEX  = 2'd1,
    PH_DEC  = 2'd2,
    PH_STOP = 2'd3
  } phase_e;

  typedef struct packed {
    logic       valid;
    logic [3:0] nibble;
  } hex_digit_t;

  // Decode one hex digit (0-9, a-f, A-F)
  function automatic hex_digit_t hex_decode(input logic [CHAR_W-1:0] c);
    hex_digit_t d;
    d.valid  = 1'b1;
    d.nibble = 4'd0;
    if (c >= CH_0 && c <= CH_9) begin
      d.nibble = c[3:0];
    end else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
      d.nibble = c[3:0] + 4'd9;
    end else begin
      d.valid = 1'b0;
    end
    return d;
  endfunction

endpackage

// File: rtl/number_string_parser.sv
// Number string parser top level: one character per request in, one value
// out per NUL-terminated string. Depends on nsp_pkg.
//
//   channel | handshake                  | payload
//   --------+----------------------------+-----------------
//   in      | in_valid_i / in_stall_o    | char_in_i [7:0]
//   out     | out_valid_o / out_stall_i  | value_o  [31:0]
//
// One character per cycle unless the input stalls. A character is held in
// the input register, then updates phase and accumulator in one step; a NUL
// there loads the result register and raises out_valid_o.
// Reset clears phase, accumulator and both valid flags.
// Input stalls only while a NUL waits in the input register and the result
// register is still held by out_stall_i; other characters keep flowing.
module number_string_parser #(
  parameter int unsigned ACC_BITS = nsp_pkg::ACC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [nsp_pkg::CHAR_W-1:0]   char_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [nsp_pkg::VALUE_W-1:0]  value_o
);
  import nsp_pkg::*;

  logic                 in_vld_q;
  logic [CHAR_W-1:0]    char_q;
  phase_e               phase_q, phase_d;
  logic [ACC_BITS-1:0]  acc_q, acc_d;
  logic                 out_vld_q, out_vld_d;
  logic [VALUE_W-1:0]   value_q, value_d;

  logic                 is_nul;
  logic                 is_dec;
  hex_digit_t           hex;
  logic                 proc_ok;
  logic                 step;
  logic [ACC_BITS-1:0]  dec_digit;
  logic [ACC_BITS-1:0]  hex_digit;
  logic [ACC_BITS-1:0]  acc_times10;
  logic [ACC_BITS-1:0]  acc_shift4;

  // Decode the registered character
  assign is_nul    = (char_q == CH_NUL);
  assign is_dec    = (char_q >= CH_0) && (char_q <= CH_9);
  assign hex       = hex_decode(char_q);
  assign dec_digit = ACC_BITS'(char_q[3:0]);
  assign hex_digit = ACC_BITS'(hex.nibble);

  // Times ten as two shifts and an add, plus the digit; wraps at ACC_BITS
  assign acc_times10 = (acc_q << 3) + (acc_q << 1) + dec_digit;
  assign acc_shift4  = (acc_q << 4) | hex_digit;

  // Stall only a NUL that cannot yet reach the result register
  assign proc_ok    = !(in_vld_q && is_nul) || !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && proc_ok;
  assign in_stall_o = !proc_ok;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (step) begin
      if (is_nul) begin
        phase_d = PH_SKIP;
      end else begin
        unique case (phase_q)
          PH_SKIP: begin
            if (char_q == CH_SPACE) begin
              phase_d = PH_SKIP;
            end else if (char_q == CH_DOLLAR) begin
              phase_d = PH_HEX;
            end else if (is_dec) begin
              phase_d = PH_DEC;
            end else begin
              phase_d = PH_STOP;
            end
          end
          PH_HEX:  phase_d = hex.valid ? PH_HEX : PH_STOP;
          PH_DEC:  phase_d = is_dec ? PH_DEC : PH_STOP;
          PH_STOP: phase_d = PH_STOP;
          default: phase_d = PH_STOP;
        endcase
      end
    end
  end

  // Next accumulator
  always_comb begin
    acc_d = acc_q;
    if (step) begin
      if (is_nul) begin
        acc_d = '0;
      end else begin
        unique case (phase_q)
          PH_SKIP: if (is_dec) acc_d = dec_digit;
          PH_HEX:  if (hex.valid) acc_d = acc_shift4;
          PH_DEC:  if (is_dec) acc_d = acc_times10;
          PH_STOP: acc_d = acc_q;
          default: acc_d = acc_q;
        endcase
      end
    end
  end

  // Fit the accumulator to the value field
  generate
    if (ACC_BITS >= VALUE_W) begin : g_trunc
      assign value_d = acc_q[VALUE_W-1:0];
    end else begin : g_ext
      assign value_d = {{(VALUE_W-ACC_BITS){1'b0}}, acc_q};
    end
  endgenerate

  // Result valid: hold while stalled, else load on a NUL step
  always_comb begin
    if (out_vld_q && out_stall_i) begin
      out_vld_d = 1'b1;
    end else begin
      out_vld_d = step && is_nul;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      phase_q   <= PH_SKIP;
      acc_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (proc_ok) begin
        in_vld_q <= in_valid_i;
      end
      phase_q   <= phase_d;
      acc_q     <= acc_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (proc_ok && in_valid_i) begin
      char_q <= char_in_i;
    end
    if (step && is_nul) begin
      value_q <= value_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign value_o     = value_q;

  // Skip phase never carries digits
  a_skip_acc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SKIP) |-> (acc_q == '0))
    else $error("accumulator nonzero while skipping spaces");

  // A terminator returns the parser to its start state
  a_nul_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && is_nul) |=> (phase_q == PH_SKIP) && (acc_q == '0) && out_vld_q)
    else $error("terminator did not restart the parser");

  // Input stalls only behind a blocked terminator
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && is_nul && out_vld_q && out_stall_i))
    else $error("input stalled without a waiting terminator");

  // A new result follows a processed terminator
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(in_vld_q && is_nul))
    else $error("result raised without a terminator");

endmodule
